/* hw/rtl/sha_pkg.sv */
//------------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the streaming SHA-256 hasher.
//------------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       put_byte;     // write pad_byte/data into buffer
        logic [7:0] byte_value;
        logic       add_len;      // bit length += 8
        logic       load_vars;    // working vars <= chain value
        logic       do_round;
        logic [5:0] round;
        logic       update_chain;
        logic       reset_msg;    // chain, position, length back to start
        logic [2:0] emit_index;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0]  byte_pos;
        logic [63:0] bit_len;
    } sha_status_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

/* hw/rtl/sha_datapath.sv */
//------------------------------------------------------------------------------
// sha_datapath
// Block buffer, rolling message schedule, one round per cycle, chain value.
//------------------------------------------------------------------------------
module sha_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::sha_cmd_t   cmd,
    output sha_pkg::sha_status_t status,
    output logic [31:0]         digest
);
    import sha_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] buf_reg [16];
    logic [31:0] var_reg [8];
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;

    logic [31:0] w, w15, w2, sg0, sg1, s1, ch, s0, mj, t1, t2;
    logic [3:0]  widx;
    logic [3:0]  bidx;
    logic [4:0]  bsh;
    logic [31:0] bword;

    always_comb
    begin
        widx = cmd.round[3:0];
        w15  = buf_reg[widx + 4'd1];
        w2   = buf_reg[widx + 4'd14];
        sg0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        sg1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        if (cmd.round < 6'd16)
            w = buf_reg[widx];
        else
            w = buf_reg[widx] + sg0 + buf_reg[widx + 4'd9] + sg1;
        s1 = {var_reg[4][5:0], var_reg[4][31:6]} ^ {var_reg[4][10:0], var_reg[4][31:11]}
           ^ {var_reg[4][24:0], var_reg[4][31:25]};
        ch = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1 = var_reg[7] + s1 + ch + K_TAB[cmd.round] + w;
        s0 = {var_reg[0][1:0], var_reg[0][31:2]} ^ {var_reg[0][12:0], var_reg[0][31:13]}
           ^ {var_reg[0][21:0], var_reg[0][31:22]};
        mj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
           ^ (var_reg[1] & var_reg[2]);
        t2 = s0 + mj;
        bidx = pos_reg[5:2];
        bsh  = {~pos_reg[1:0], 3'b000};
        // A word is cleared when its first byte lands.
        bword = ((pos_reg[1:0] == 2'd0) ? 32'd0 : buf_reg[bidx])
              | ({24'd0, cmd.byte_value} << bsh);
        for (int i = 0; i < 8; i++)
            chain_next[i] = chain_reg[i] + var_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= H_INIT[i];
        end
        else
        begin
            if (cmd.reset_msg)
            begin
                pos_reg <= '0;
                len_reg <= '0;
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= H_INIT[i];
            end
            else
            begin
                if (cmd.put_byte)
                    pos_reg <= pos_reg + 6'd1;
                if (cmd.add_len)
                    len_reg <= len_reg + 64'd8;
                if (cmd.update_chain)
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
            buf_reg[bidx] <= bword;
        else if (cmd.do_round && cmd.round >= 6'd16)
            buf_reg[widx] <= w;
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
                var_reg[i] <= chain_reg[i];
        end
        else if (cmd.do_round)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    assign status.byte_pos = pos_reg;
    assign status.bit_len  = len_reg;
    assign digest          = chain_reg[cmd.emit_index];

endmodule

/* hw/rtl/sha_ctrl.sv */
//------------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, 64-round compression, padding and digest output.
//------------------------------------------------------------------------------
module sha_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    input  logic                 in_has,
    input  logic                 in_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           out_index,
    output sha_pkg::sha_cmd_t    cmd,
    input  sha_pkg::sha_status_t status
);
    import sha_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  emit_reg, emit_next;
    logic [3:0]  lbyte_reg, lbyte_next;   // length bytes sent, 8 = none pending
    logic        fin_reg, fin_next;       // finishing the message
    logic        pad1_reg, pad1_next;     // 0x80 byte not yet appended
    logic [63:0] len_reg, len_next;       // frozen length during padding
    logic [5:0]  npos;
    logic [2:0]  lsel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            emit_reg  <= '0;
            lbyte_reg <= '0;
            fin_reg   <= 1'b0;
            pad1_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            emit_reg  <= emit_next;
            lbyte_reg <= lbyte_next;
            fin_reg   <= fin_next;
            pad1_reg  <= pad1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        emit_next  = emit_reg;
        lbyte_next = lbyte_reg;
        fin_next   = fin_reg;
        pad1_next  = pad1_reg;
        len_next   = len_reg;
        cmd        = '0;
        cmd.round      = round_reg;
        cmd.emit_index = emit_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        npos       = status.byte_pos + 6'd1;
        lsel       = 3'd7 - lbyte_reg[2:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.put_byte   = in_has;
                    cmd.add_len    = in_has;
                    cmd.byte_value = in_byte;
                    if (in_end)
                    begin
                        fin_next   = 1'b1;
                        pad1_next  = 1'b1;
                        lbyte_next = '0;
                        len_next   = in_has ? status.bit_len + 64'd8 : status.bit_len;
                    end
                    if (in_has && npos == 6'd0)
                    begin
                        cmd.load_vars = 1'b1;
                        round_next    = '0;
                        state_next    = ST_ROUND;
                    end
                    else if (in_end)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update_chain = 1'b1;
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (lbyte_reg == 4'd8)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                // One padding byte per cycle: marker, zero fill, then length.
                cmd.put_byte = 1'b1;
                if (pad1_reg)
                begin
                    cmd.byte_value = PAD_BYTE;
                    pad1_next      = 1'b0;
                end
                else if (status.byte_pos == LEN_POS || lbyte_reg != 4'd0)
                begin
                    // The length starts at byte 56 of the first block that has room for it.
                    cmd.byte_value = len_reg[{lsel, 3'b000} +: 8];
                    lbyte_next     = lbyte_reg + 4'd1;
                end
                else
                    cmd.byte_value = 8'd0;
                if (npos == 6'd0)
                begin
                    cmd.load_vars = 1'b1;
                    round_next    = '0;
                    state_next    = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        cmd.reset_msg = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_index = emit_reg;

endmodule

/* hw/rtl/sha256_stream_hasher.sv */
// A byte that fills no block is taken without a stall; a byte that completes a
// 64-byte block holds input through its compression rounds and the chain update.
// The final item adds padding bytes, one per cycle, and compression per final block,
// then eight digest transactions at one per cycle when output is not stalled.
// The single round unit limits the rate: input stalls while a block is compressed.
// Reset (asynchronous, active low) loads the standard initial hash and clears length.
//------------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 hasher taking at most one message byte per transaction.
//------------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;

    sha_cmd_t    cmd;
    sha_status_t status;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (data_byte),
        .in_has    (has_byte),
        .in_end    (end_of_message),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (word_index),
        .cmd       (cmd),
        .status    (status)
    );

    sha_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .digest (digest_word)
    );

    assign last_word = (word_index == 3'd7);

endmodule

/* hw/rtl/sha_checker.sv */
//------------------------------------------------------------------------------
// sha_checker
// Port-level checks on the hasher, bound to the top level.
//------------------------------------------------------------------------------
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while digest is sent");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=>
        (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(digest_word)))
        else $error("stalled digest word changed");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

/* tb/sv/sha256_digest_checker.sv */
//------------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the hasher, computes SHA-256 of each message
// independently and compares every digest transaction with the expected one.
//------------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          words_pending,
    output int          digests_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_txn_t;

    logic [31:0] hash_state [8];
    logic [31:0] msg_words [16];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;
    digest_txn_t exp_fifo [16];
    int          wr_ptr;
    int          rd_ptr;
    int          exp_count;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_words();
        logic [31:0] v [8];
        logic [31:0] sched [64];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                sched[r] = msg_words[r];
            else
                sched[r] = sched[r-16] + sched[r-7]
                    + (rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3))
                    + (rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10));
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_TAB[r] + sched[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        msg_words[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = b;
        fill_pos = fill_pos + 1'b1;
        if (fill_pos == 0)
            compress_words();
    endtask

    task automatic start_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = sha_pkg::H_INIT[i];
        fill_pos = '0;
        msg_bits = '0;
    endtask

    task automatic store_expected(input digest_txn_t txn);
        if (exp_count == 16)
        begin
            $display("%0t: expected-digest store overflow, expected %0d free, actual 0",
                     $time, 1);
            fail_count++;
        end
        else
        begin
            exp_fifo[wr_ptr] = txn;
            wr_ptr = (wr_ptr + 1) % 16;
            exp_count++;
        end
    endtask

    task automatic take_item(input logic [7:0] b, input logic hb, input logic eom);
        logic [63:0] len;
        digest_txn_t txn;
        if (hb)
        begin
            absorb_byte(b);
            msg_bits = msg_bits + 64'd8;
        end
        if (eom)
        begin
            len = msg_bits;
            absorb_byte(sha_pkg::PAD_BYTE);
            while (fill_pos != sha_pkg::LEN_POS)
                absorb_byte(8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(len[63 - 8 * k -: 8]);
            for (int k = 0; k < 8; k++)
            begin
                txn.word  = hash_state[k];
                txn.index = 3'(k);
                txn.last  = (k == 7);
                store_expected(txn);
            end
            start_message();
        end
    endtask

    initial
    begin
        fail_count = 0;
        digests_seen = 0;
        wr_ptr = 0;
        rd_ptr = 0;
        exp_count = 0;
        start_message();
    end

    assign words_pending = exp_count;

    always @(posedge clk)
    begin
        digest_txn_t exp_txn;
        if (rst_n && in_valid && !in_stall)
            take_item(data_byte, has_byte, end_of_message);
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_count == 0)
            begin
                $display("%0t: unexpected digest transaction word=%h index=%0d last=%0d",
                         $time, digest_word, word_index, last_word);
                fail_count++;
            end
            else
            begin
                exp_txn = exp_fifo[rd_ptr];
                rd_ptr = (rd_ptr + 1) % 16;
                exp_count--;
                if (digest_word !== exp_txn.word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, exp_txn.word, digest_word);
                    fail_count++;
                end
                if (word_index !== exp_txn.index)
                begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, exp_txn.index, word_index);
                    fail_count++;
                end
                if (last_word !== exp_txn.last)
                begin
                    $display("%0t: last_word expected %0d actual %0d",
                             $time, exp_txn.last, last_word);
                    fail_count++;
                end
                if (exp_txn.last)
                    digests_seen++;
            end
        end
    end

endmodule

/* tb/sv/sha256_stream_hasher_tb.sv */
//------------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Drives byte streams into the hasher (empty, short, block-boundary and
// multi-block messages) with random idling on both sides, and relies on the
// checker for digest comparison.
//------------------------------------------------------------------------------
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          words_pending;
    int          digests_seen;
    bit          quiet_phase;
    bit          hold_output;
    int          items_sent;

    sha256_stream_hasher uut (.*);

    sha256_digest_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stall bursts, or a long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_output = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one transaction and holds it until accepted.
    task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        has_byte <= hb;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_message(input int nbytes, input bit junk);
        for (int i = 0; i < nbytes; i++)
        begin
            // Now and then an item with no byte; its data must be ignored.
            if (junk && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        if (nbytes > 0 && $urandom_range(0, 1))
            send_item(8'($urandom), 1'b1, 1'b1);
        else
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // The checker has seen the last accepted transaction before words_pending is polled.
    task automatic drain_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        has_byte = 1'b0;
        end_of_message = 1'b0;
        quiet_phase = 1'b0;
        hold_output = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, extreme bytes, ignored data, one-byte message.
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        drain_digests();

        // Receiver held off while the sender keeps offering messages.
        hold_output = 1'b1;
        send_message(3, 1'b0);
        send_message(0, 1'b0);
        send_message(5, 1'b1);
        drain_digests();

        // Padding boundaries: 55 or 56 bytes, then 56 or 57 bytes, then a two-block message.
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        drain_digests();
        send_message(64, 1'b1);

        while (items_sent < 190)
            send_message($urandom_range(0, 12), 1'b1);
        quiet_phase = 1'b1;
        for (int m = 0; m < 2; m++)
            send_message($urandom_range(0, 12), 1'b1);
        drain_digests();
        repeat (20) @(posedge clk);

        $display("Hashed %0d messages over %0d input transactions, including empty,",
                 digests_seen, items_sent);
        $display("pad-boundary and multi-block messages under stalls on both sides.");
        if (words_pending != 0)
            $display("%0t: digest words still owed: expected 0 actual %0d",
                     $time, words_pending);
        if (fail_count == 0 && words_pending == 0)
            $display("sha256_stream_hasher_tb: clean");
        else
            $display("sha256_stream_hasher_tb: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("sha256_stream_hasher_tb: errors");
        $finish;
    end

endmodule
